### rtl/trd_pkg.sv
// Shared types and constants for the run-length image decoder.
// Used by trd_ctrl, trd_datapath, tga_rle_decoder_unit and the sim checker and bench; depends on nothing.
package trd_pkg;

    localparam int PIXEL_W            = 32;
    localparam int MAX_PIXEL_BYTES_DEF = 4;
    localparam int IMAGE_W            = 32;
    localparam int PACKET_W           = 8;
    localparam int PB_W               = 3;

    localparam logic [PB_W-1:0]  PIXEL_BYTES_RESET = 3'd3;
    localparam int               HDR_RUN_BIT       = 7;
    localparam logic [7:0]       HDR_RUN_FLAG      = 8'h80;
    localparam logic [7:0]       HDR_COUNT_MASK    = 8'h7F;

    // register indexes on the configuration port
    localparam logic CFG_PIXEL_BYTES  = 1'b0;
    localparam logic CFG_IMAGE_PIXELS = 1'b1;

    typedef enum logic [1:0] {
        ACT_DATA  = 2'd0,
        ACT_START = 2'd1,
        ACT_END   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_BUSY     = 2'd0,
        STAT_DONE     = 2'd1,
        STAT_OVERFLOW = 2'd2,
        STAT_TRUNC    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_HEADER      = 3'd0,
        ST_RUN         = 3'd1,
        ST_RAW         = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_ENDED_OK    = 3'd4,
        ST_ENDED_TRUNC = 3'd5,
        ST_EMIT        = 3'd6
    } state_t;

    typedef struct packed {
        logic    clear;
        logic    hdr_load;
        logic    byte_acc;
        logic    raw_out;
        logic    run_start;
        logic    run_step;
        logic    raw_ovf;
        logic    end_out;
        status_t end_status;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic hdr_is_run;
        logic wr_ge_img;
        logic wr_gt_img;
        logic wr_eq_img;
        logic raw_fits;
        logic pix_done;
        logic pl_one;
        logic run_last;
        logic run_over;
    } sts_t;

endpackage

### rtl/trd_ctrl.sv
// Packet-phase state machine of the run-length decoder.
// Depends on trd_pkg; drives datapath commands from trd_datapath status.
module trd_ctrl
    import trd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] action,
    input  sts_t       sts,
    output logic       s_tready,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   s_fire;

    assign s_tready = (state_reg != ST_EMIT) && sts.slot_free;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HEADER;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        if (state_reg == ST_EMIT) begin
            if (sts.slot_free && sts.run_last) begin
                state_next = sts.run_over ? ST_OVERFLOW : ST_HEADER;
            end
        end else if (s_fire) begin
            case (action)
                ACT_START: state_next = ST_HEADER;
                ACT_END: begin
                    if (state_reg == ST_OVERFLOW || sts.wr_gt_img) begin
                        state_next = ST_OVERFLOW;
                    end else if (state_reg == ST_ENDED_OK ||
                                 (state_reg == ST_HEADER && sts.wr_eq_img)) begin
                        state_next = ST_ENDED_OK;
                    end else begin
                        state_next = ST_ENDED_TRUNC;
                    end
                end
                ACT_DATA: begin
                    case (state_reg)
                        ST_HEADER: begin
                            if (!sts.wr_ge_img) begin
                                if (sts.hdr_is_run) begin
                                    state_next = ST_RUN;
                                end else if (!sts.raw_fits) begin
                                    state_next = ST_OVERFLOW;
                                end else begin
                                    state_next = ST_RAW;
                                end
                            end
                        end
                        ST_RAW: begin
                            if (sts.pix_done && sts.pl_one) begin
                                state_next = ST_HEADER;
                            end
                        end
                        ST_RUN: begin
                            if (sts.pix_done) begin
                                state_next = ST_EMIT;
                            end
                        end
                        default: state_next = state_reg;
                    endcase
                end
                default: state_next = state_reg;
            endcase
        end
    end

    // datapath commands
    always_comb begin
        cmd = '0;
        cmd.end_status = STAT_BUSY;
        if (state_reg == ST_EMIT) begin
            cmd.run_step = sts.slot_free;
        end else if (s_fire) begin
            case (action)
                ACT_START: cmd.clear = 1'b1;
                ACT_END: begin
                    cmd.end_out = 1'b1;
                    if (state_reg == ST_OVERFLOW || sts.wr_gt_img) begin
                        cmd.end_status = STAT_OVERFLOW;
                    end else if (state_reg == ST_ENDED_OK ||
                                 (state_reg == ST_HEADER && sts.wr_eq_img)) begin
                        cmd.end_status = STAT_DONE;
                    end else begin
                        cmd.end_status = STAT_TRUNC;
                    end
                end
                ACT_DATA: begin
                    case (state_reg)
                        ST_HEADER: begin
                            if (!sts.wr_ge_img) begin
                                if (sts.hdr_is_run || sts.raw_fits) begin
                                    cmd.hdr_load = 1'b1;
                                end else begin
                                    cmd.raw_ovf = 1'b1;
                                end
                            end
                        end
                        ST_RAW: begin
                            cmd.byte_acc = 1'b1;
                            cmd.raw_out  = sts.pix_done;
                        end
                        ST_RUN: begin
                            cmd.byte_acc  = 1'b1;
                            cmd.run_start = sts.pix_done;
                        end
                        default: cmd.byte_acc = 1'b0;
                    endcase
                end
                default: cmd.clear = 1'b0;
            endcase
        end
    end

    // a completed run pixel always moves on to expansion
    a_run_start_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.run_start |=> state_reg == ST_EMIT)
        else $error("run pixel completed without entering expansion");

endmodule

### rtl/trd_datapath.sv
// Datapath of the run-length decoder: config registers, pixel assembly,
// counters and the result register. Depends on trd_pkg.
module trd_datapath
    import trd_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [IMAGE_W-1:0] cfg_wdata,
    input  logic [7:0]         in_byte,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               m_tready,
    output logic               out_valid,
    output logic [PIXEL_W-1:0] out_first,
    output logic [PIXEL_W-1:0] out_second,
    output logic [1:0]         out_count,
    output status_t            out_status,
    output logic               out_last
);

    localparam int IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [PB_W-1:0]     pb_reg, pb_next;
    logic [IMAGE_W-1:0]  img_reg, img_next;
    logic [PACKET_W-1:0] pl_reg, pl_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PIXEL_W-1:0]  buf_reg, buf_next;
    logic [IMAGE_W-1:0]  wr_reg, wr_next;
    logic [PACKET_W-1:0] take_reg, take_next;
    logic                over_reg, over_next;
    logic                exact_reg, exact_next;
    logic                ov_reg, ov_next;
    logic [PIXEL_W-1:0]  first_reg, first_next;
    logic [PIXEL_W-1:0]  second_reg, second_next;
    logic [1:0]          cnt_reg, cnt_next;
    status_t             stat_reg, stat_next;
    logic                last_reg, last_next;

    logic [PB_W-1:0]     pb_eff;
    logic [PB_W-1:0]     idx_plus;
    logic [PIXEL_W-1:0]  buf_acc;
    logic [IMAGE_W-1:0]  remaining;
    logic [IMAGE_W-1:0]  pl_ext;
    logic [IMAGE_W-1:0]  wr_inc;
    logic [PACKET_W-1:0] hdr_cnt;
    logic [1:0]          step_cnt;
    logic                push;

    // pixel size clamp
    always_comb begin
        if (pb_reg == '0) begin
            pb_eff = PB_W'(1);
        end else if (pb_reg > PB_W'(MAX_PIXEL_BYTES)) begin
            pb_eff = PB_W'(MAX_PIXEL_BYTES);
        end else begin
            pb_eff = pb_reg;
        end
    end

    assign idx_plus  = PB_W'(idx_reg) + PB_W'(1);
    assign buf_acc   = buf_reg | (PIXEL_W'(in_byte) << {idx_reg, 3'b000});
    assign hdr_cnt   = (in_byte & HDR_COUNT_MASK) + PACKET_W'(1);
    assign remaining = (img_reg > wr_reg) ? (img_reg - wr_reg) : '0;
    assign pl_ext    = IMAGE_W'(pl_reg);
    assign wr_inc    = wr_reg + IMAGE_W'(1);
    assign step_cnt  = (take_reg >= PACKET_W'(2)) ? 2'd2 : {1'b0, take_reg[0]};
    assign push      = cmd.raw_out | cmd.run_step | cmd.raw_ovf | cmd.end_out;

    always_comb begin
        sts.slot_free  = !ov_reg || m_tready;
        sts.hdr_is_run = (in_byte & HDR_RUN_FLAG) != 8'h00;
        sts.wr_ge_img  = wr_reg >= img_reg;
        sts.wr_gt_img  = wr_reg > img_reg;
        sts.wr_eq_img  = wr_reg == img_reg;
        sts.raw_fits   = ({1'b0, wr_reg} + (IMAGE_W + 1)'(hdr_cnt)) <= {1'b0, img_reg};
        sts.pix_done   = idx_plus >= pb_eff;
        sts.pl_one     = pl_reg == PACKET_W'(1);
        sts.run_last   = take_reg <= PACKET_W'(2);
        sts.run_over   = over_reg;
    end

    always_comb begin
        pb_next     = pb_reg;
        img_next    = img_reg;
        pl_next     = pl_reg;
        idx_next    = idx_reg;
        buf_next    = buf_reg;
        wr_next     = wr_reg;
        take_next   = take_reg;
        over_next   = over_reg;
        exact_next  = exact_reg;
        first_next  = first_reg;
        second_next = second_reg;
        cnt_next    = cnt_reg;
        stat_next   = stat_reg;
        last_next   = last_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_PIXEL_BYTES:  pb_next  = cfg_wdata[PB_W-1:0];
                CFG_IMAGE_PIXELS: img_next = cfg_wdata;
                default:          pb_next  = pb_reg;
            endcase
        end

        if (cmd.clear) begin
            pl_next  = '0;
            idx_next = '0;
            buf_next = '0;
            wr_next  = '0;
        end

        if (cmd.hdr_load) begin
            pl_next  = hdr_cnt;
            idx_next = '0;
            buf_next = '0;
        end

        if (cmd.byte_acc) begin
            buf_next = buf_acc;
            idx_next = sts.pix_done ? '0 : idx_plus[IDX_W-1:0];
        end

        // one literal pixel per result
        if (cmd.raw_out) begin
            buf_next    = '0;
            wr_next     = wr_inc;
            pl_next     = pl_reg - PACKET_W'(1);
            first_next  = buf_acc;
            second_next = '0;
            cnt_next    = 2'd1;
            stat_next   = (sts.pl_one && wr_inc == img_reg) ? STAT_DONE : STAT_BUSY;
            last_next   = 1'b1;
        end

        // size the run against what is left of the image
        if (cmd.run_start) begin
            over_next  = pl_ext > remaining;
            exact_next = pl_ext == remaining;
            take_next  = (pl_ext > remaining) ? remaining[PACKET_W-1:0] : pl_reg;
            pl_next    = '0;
        end

        if (cmd.run_step) begin
            first_next  = (step_cnt != 2'd0) ? buf_reg : '0;
            second_next = (step_cnt == 2'd2) ? buf_reg : '0;
            cnt_next    = step_cnt;
            last_next   = sts.run_last;
            if (!sts.run_last) begin
                stat_next = STAT_BUSY;
            end else if (over_reg) begin
                stat_next = STAT_OVERFLOW;
            end else begin
                stat_next = exact_reg ? STAT_DONE : STAT_BUSY;
            end
            take_next = take_reg - PACKET_W'(step_cnt);
            wr_next   = wr_reg + IMAGE_W'(step_cnt);
        end

        if (cmd.raw_ovf || cmd.end_out) begin
            first_next  = '0;
            second_next = '0;
            cnt_next    = 2'd0;
            stat_next   = cmd.raw_ovf ? STAT_OVERFLOW : cmd.end_status;
            last_next   = 1'b1;
        end

        if (push) begin
            ov_next = 1'b1;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end else begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_reg  <= PIXEL_BYTES_RESET;
            img_reg <= '0;
            pl_reg  <= '0;
            idx_reg <= '0;
            buf_reg <= '0;
            wr_reg  <= '0;
            ov_reg  <= 1'b0;
        end else begin
            pb_reg  <= pb_next;
            img_reg <= img_next;
            pl_reg  <= pl_next;
            idx_reg <= idx_next;
            buf_reg <= buf_next;
            wr_reg  <= wr_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        take_reg   <= take_next;
        over_reg   <= over_next;
        exact_reg  <= exact_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        cnt_reg    <= cnt_next;
        stat_reg   <= stat_next;
        last_reg   <= last_next;
    end

    assign out_valid  = ov_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;
    assign out_count  = cnt_reg;
    assign out_status = stat_reg;
    assign out_last   = last_reg;

    a_push_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!ov_reg || m_tready))
        else $error("result written over one not yet taken");

    a_empty_step_is_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.run_step && take_reg == '0) |-> over_reg)
        else $error("empty run step without overflow");

endmodule

### rtl/tga_rle_decoder_unit.sv
// Top level of the TGA run-length decoder.
// Depends on trd_pkg, trd_ctrl and trd_datapath.
//
// Decodes a TGA run-length pixel stream fed one request (one compressed
// byte, or a start / end action) at a time. A header byte opens a packet of
// 1 to 128 pixels; a raw packet returns each literal pixel in its own
// result, a run packet returns its repeated pixel up to two per result.
// Writing beyond image_pixels raises an overflow status; an end request
// reports complete, truncated or overflow. Rate: header and pixel bytes are
// taken one per cycle while the output register is free or being drained;
// the byte that completes a run pixel starts an expansion of ceil(n/2)
// results (n = pixels of the run that fit the image, one empty result when
// none fit), one result per cycle while the output register is free or
// being drained, during which s_tready stays low. A single output register
// sits between the sides, so a waiting result stalls the next request. No
// clearing pass is needed after reset. Write configuration only while the block is idle.
module tga_rle_decoder_unit
    import trd_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [IMAGE_W-1:0] cfg_wdata,
    // compressed input
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic [1:0]         s_tuser,   // [1:0] action
    // decoded pixels
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata,   // [31:0] pixel_first, [63:32] pixel_second,
                                          // [65:64] pixel_count, rest zero
    output logic               m_tlast,   // last
    output logic [1:0]         m_tuser    // [1:0] status
);

    cmd_t               cmd;
    sts_t               sts;
    logic [PIXEL_W-1:0] out_first;
    logic [PIXEL_W-1:0] out_second;
    logic [1:0]         out_count;
    status_t            out_status;

    // phase sequencing and run expansion control
    trd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // pixel assembly, counters and result register
    trd_datapath #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_byte    (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_first  (out_first),
        .out_second (out_second),
        .out_count  (out_count),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    // pack the result: fields from the low bits up, zero fill to bytes
    assign m_tdata = {6'b000000, out_count, out_second, out_first};
    assign m_tuser = out_status;

    // results without pixels are always the final one of their request
    a_empty_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[65:64] == 2'd0) |-> m_tlast)
        else $error("pixel-less result not marked last");

endmodule

### sim/rle_pixel_checker.sv
// Checker for the TGA run-length decoder: watches the configuration port and
// both stream channels, predicts the pixel results of each request and compares.
// Depends on trd_pkg for the action, status and state codes.
module rle_pixel_checker
    import trd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
        logic [1:0]  count;
        logic        last;
        status_t     status;
    } pixel_result_t;

    // decoder shadow: configuration and packet state
    logic [PB_W-1:0]    pix_bytes_reg;
    logic [IMAGE_W-1:0] img_total;
    state_t             dec_phase;
    logic [7:0]         pkt_left;
    logic [1:0]         byte_idx;
    logic [31:0]        pix_buf;
    logic [31:0]        pix_written;

    pixel_result_t pixels_due[$];
    int mismatches = 0;
    int due_count = 0;

    assign errors  = mismatches;
    assign pending = due_count;

    function automatic pixel_result_t make_result(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [1:0] cnt, input status_t st);
        pixel_result_t r;
        r.first  = a;
        r.second = b;
        r.count  = cnt;
        r.last   = 1'b0;
        r.status = st;
        return r;
    endfunction

    task automatic clear_decoder();
        dec_phase   = ST_HEADER;
        pkt_left    = '0;
        byte_idx    = '0;
        pix_buf     = '0;
        pix_written = '0;
    endtask

    task automatic decode_request(input logic [1:0] act, input logic [7:0] b);
        pixel_result_t outs[$];
        int unsigned   bpp;
        logic [7:0]    cnt;
        logic [31:0]   room;
        logic [31:0]   take;
        logic [31:0]   done;
        logic          over;
        status_t       st;
        case (act)
            ACT_START: clear_decoder();
            ACT_END: begin
                if (dec_phase == ST_OVERFLOW || pix_written > img_total) begin
                    st = STAT_OVERFLOW;
                    dec_phase = ST_OVERFLOW;
                end else if (dec_phase == ST_ENDED_OK ||
                             (dec_phase == ST_HEADER && pix_written == img_total)) begin
                    st = STAT_DONE;
                    dec_phase = ST_ENDED_OK;
                end else begin
                    st = STAT_TRUNC;
                    dec_phase = ST_ENDED_TRUNC;
                end
                outs.insert(outs.size(), make_result('0, '0, 2'd0, st));
            end
            ACT_DATA: begin
                if (dec_phase == ST_HEADER) begin
                    cnt = (b & HDR_COUNT_MASK) + 8'd1;
                    // headers past the image total are dropped silently
                    if (pix_written < img_total) begin
                        if (b[HDR_RUN_BIT]) begin
                            dec_phase = ST_RUN;
                        end else if ({1'b0, pix_written} + 33'(cnt) > {1'b0, img_total}) begin
                            dec_phase = ST_OVERFLOW;
                            outs.insert(outs.size(), make_result('0, '0, 2'd0, STAT_OVERFLOW));
                        end else begin
                            dec_phase = ST_RAW;
                        end
                        if (dec_phase == ST_RUN || dec_phase == ST_RAW) begin
                            pkt_left = cnt;
                            byte_idx = '0;
                            pix_buf  = '0;
                        end
                    end
                end else if (dec_phase == ST_RUN || dec_phase == ST_RAW) begin
                    bpp = (pix_bytes_reg == 0) ? 1 :
                          (pix_bytes_reg > MAX_PIXEL_BYTES_DEF) ? MAX_PIXEL_BYTES_DEF :
                          pix_bytes_reg;
                    pix_buf |= 32'(b) << (8 * byte_idx);
                    if (byte_idx + 1 < bpp) begin
                        byte_idx = byte_idx + 2'd1;
                    end else begin
                        byte_idx = '0;
                        if (dec_phase == ST_RAW) begin
                            pix_written = pix_written + 1;
                            pkt_left = pkt_left - 8'd1;
                            st = (pkt_left == 0 && pix_written == img_total) ? STAT_DONE
                                                                             : STAT_BUSY;
                            outs.insert(outs.size(), make_result(pix_buf, '0, 2'd1, st));
                            if (pkt_left == 0) dec_phase = ST_HEADER;
                        end else begin
                            // expand the run in pairs, clipped at the image total
                            room = (img_total > pix_written) ? img_total - pix_written : '0;
                            take = (32'(pkt_left) < room) ? 32'(pkt_left) : room;
                            over = 32'(pkt_left) > room;
                            done = '0;
                            while (done < take) begin
                                if (take - done >= 2) begin
                                    outs.insert(outs.size(),
                                                make_result(pix_buf, pix_buf, 2'd2,
                                                            STAT_BUSY));
                                    done = done + 2;
                                end else begin
                                    outs.insert(outs.size(),
                                                make_result(pix_buf, '0, 2'd1, STAT_BUSY));
                                    done = done + 1;
                                end
                            end
                            pix_written = pix_written + take;
                            pkt_left = '0;
                            if (outs.size() == 0)
                                outs.insert(outs.size(),
                                            make_result('0, '0, 2'd0, STAT_OVERFLOW));
                            if (over) begin
                                outs[outs.size()-1].status = STAT_OVERFLOW;
                                dec_phase = ST_OVERFLOW;
                            end else begin
                                if (pix_written == img_total)
                                    outs[outs.size()-1].status = STAT_DONE;
                                dec_phase = ST_HEADER;
                            end
                        end
                        pix_buf = '0;
                    end
                end
            end
            default: ;
        endcase
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
        foreach (outs[i]) pixels_due.insert(pixels_due.size(), outs[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            pix_bytes_reg = PIXEL_BYTES_RESET;
            img_total     = '0;
            clear_decoder();
            pixels_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixels_due.size() == 0) begin
                    $error("unexpected result: pixel_first %0h status %0h",
                           m_tdata[31:0], m_tuser);
                    mismatches++;
                end else begin
                    want = pixels_due.pop_front();
                    check_field("pixel_first", want.first, m_tdata[31:0]);
                    check_field("pixel_second", want.second, m_tdata[63:32]);
                    check_field("pixel_count", 32'(want.count), 32'(m_tdata[65:64]));
                    check_field("tdata_pad", '0, 32'(m_tdata[71:66]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                    check_field("status", 32'(want.status), 32'(m_tuser));
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_PIXEL_BYTES) pix_bytes_reg = cfg_wdata[PB_W-1:0];
                else img_total = cfg_wdata;
            end
            if (s_tvalid && s_tready) decode_request(s_tuser, s_tdata);
        end
        due_count = pixels_due.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for tga_rle_decoder_unit: drives requests, configuration and
// result back-pressure, and reports the verdict. Depends on trd_pkg, the RTL
// and rle_pixel_checker, which does all prediction and comparison.
module tb_top;
    import trd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 410;
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with nothing moving
    localparam int HOLD_CYCLES     = 300;   // one long receiver hold-off
    localparam int SETTLE_CYCLES   = 8;     // let a header or pixel byte land
    localparam int TAIL_CYCLES     = 20;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // [31:0] pixel_first, [63:32] pixel_second, [65:64] pixel_count
    logic        m_tlast;   // last
    logic [1:0]  m_tuser;   // [1:0] status

    int check_errors;
    int check_pending;

    // shared knobs: stimulus writes steady and hold_off_go, the receiver
    // owns hold_served and hold_left
    bit steady      = 1'b0;
    bit hold_off_go = 1'b0;
    bit hold_served = 1'b0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    int fed = 0;
    logic [2:0] cur_pb = PIXEL_BYTES_RESET;

    tga_rle_decoder_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    rle_pixel_checker u_pixel_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .errors    (check_errors),
        .pending   (check_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offer one request and hold it until the decoder takes it. Valid stays
    // high on return; the next send may still drop it at random unless steady is set.
    task automatic send(input logic [1:0] act, input logic [7:0] b);
        while (!steady && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        fed++;
    endtask

    // Drop valid and wait until every predicted result has come out, then
    // give a stray header or pixel byte time to finish inside the block.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (check_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        if (idx == CFG_PIXEL_BYTES) cur_pb = v[2:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    // One image: mostly well-formed packets with random pixels, with the odd
    // stray request, a packet cut short, repeated ends and trailing bytes.
    // Stop early once the request budget is spent.
    task automatic run_image(input logic [31:0] img, input bit fresh);
        int unsigned planned;
        int unsigned cnt;
        int unsigned nbytes;
        int unsigned bpp;
        int pkts;
        bit run;
        bit broken;
        planned = 0;
        pkts    = 0;
        broken  = 1'b0;
        bpp = (cur_pb == 0) ? 1 : ((cur_pb > 4) ? 4 : cur_pb);
        if (fresh) send(ACT_START, rnd_byte());
        while (planned < img && pkts < 12 && !broken && fed < RANDOM_REQUESTS) begin
            cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            // often land exactly on the image total, otherwise overshoot at will
            if (img - planned <= 128 && $urandom_range(1) == 1) cnt = img - planned;
            run = $urandom_range(1);
            send(ACT_DATA, {run, 7'(cnt - 1)});
            nbytes = run ? bpp : cnt * bpp;
            for (int k = 0; k < nbytes; k++) begin
                if ($urandom_range(99) < 2 || fed >= RANDOM_REQUESTS) begin
                    broken = 1'b1;
                    break;
                end
                if ($urandom_range(99) < 3) send(2'($urandom_range(3)), rnd_byte());
                send(ACT_DATA, rnd_byte());
            end
            planned += cnt;
            pkts++;
        end
        send(ACT_END, rnd_byte());
        if ($urandom_range(3) == 0) send(ACT_END, rnd_byte());
        if ($urandom_range(4) == 0) send(ACT_DATA, rnd_byte());
    endtask

    // Receiver: random back-pressure, a quiet stretch, and one long hold-off
    // that fills the output register and stalls the request side.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_go && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 17);
            end
        end
    end

    // Watchdog: give up when nothing has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] img;
        int round;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_PIXEL_BYTES;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_DATA;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-byte pixels, six-pixel image: run pair, raw pixel, a run that
        // completes the image, a header after completion, repeated end,
        // unused action
        write_reg(CFG_PIXEL_BYTES, 32'd1);
        write_reg(CFG_IMAGE_PIXELS, 32'd6);
        send(ACT_DATA, 8'h81);
        send(ACT_DATA, 8'hFF);
        send(ACT_DATA, 8'h00);
        send(ACT_DATA, 8'h00);
        send(ACT_DATA, 8'h82);
        send(ACT_DATA, 8'hA5);
        send(ACT_DATA, 8'h05);
        send(ACT_END, 8'h00);
        send(ACT_END, 8'hFF);
        send(2'd3, 8'h5A);

        // pixel size above the maximum: a 128-pixel run (64 pairs), then a
        // raw packet refused at its header, a byte ignored after the error
        settle();
        write_reg(CFG_PIXEL_BYTES, 32'd7);
        write_reg(CFG_IMAGE_PIXELS, 32'd130);
        send(ACT_START, 8'hFF);
        send(ACT_DATA, HDR_RUN_FLAG | HDR_COUNT_MASK);
        send(ACT_DATA, 8'h01);
        send(ACT_DATA, 8'h80);
        send(ACT_DATA, 8'hFF);
        send(ACT_DATA, 8'h7F);
        send(ACT_DATA, 8'h02);
        send(ACT_DATA, 8'h11);
        send(ACT_END, 8'h00);

        // zero pixel size acts as one byte; a run cut at the image total
        settle();
        write_reg(CFG_PIXEL_BYTES, 32'd0);
        write_reg(CFG_IMAGE_PIXELS, 32'd1);
        send(ACT_START, 8'h00);
        send(ACT_DATA, 8'h83);
        send(ACT_DATA, 8'h3C);
        send(ACT_END, 8'h00);

        // shrink the image to zero mid-run: no pixel fits
        settle();
        write_reg(CFG_IMAGE_PIXELS, 32'hFFFF_FFFF);
        send(ACT_START, 8'h00);
        send(ACT_DATA, 8'h80);
        settle();
        write_reg(CFG_IMAGE_PIXELS, 32'd0);
        send(ACT_DATA, 8'h77);

        // shrink the image below what was written, then end
        settle();
        write_reg(CFG_IMAGE_PIXELS, 32'd2);
        send(ACT_START, 8'h00);
        send(ACT_DATA, 8'h01);
        send(ACT_DATA, 8'hAA);
        send(ACT_DATA, 8'hBB);
        settle();
        write_reg(CFG_IMAGE_PIXELS, 32'd1);
        send(ACT_END, 8'h00);

        // random images until enough requests went in
        round = 0;
        while (fed < RANDOM_REQUESTS) begin
            settle();
            steady = (round >= 5 && round < 9);
            if ($urandom_range(3) != 0) write_reg(CFG_PIXEL_BYTES, 32'($urandom_range(7)));
            case ($urandom_range(9))
                0:       img = '0;
                1:       img = '1;
                2:       img = $urandom_range(129, 300);
                default: img = $urandom_range(1, 40);
            endcase
            if ($urandom_range(4) != 0) write_reg(CFG_IMAGE_PIXELS, img);
            if (round == 2) begin
                // long runs while the receiver holds off
                write_reg(CFG_PIXEL_BYTES, 32'd1);
                write_reg(CFG_IMAGE_PIXELS, 32'd1000);
                hold_off_go = 1'b1;
                send(ACT_START, rnd_byte());
                repeat (4) begin
                    send(ACT_DATA, HDR_RUN_FLAG | HDR_COUNT_MASK);
                    send(ACT_DATA, rnd_byte());
                end
                send(ACT_END, rnd_byte());
            end else begin
                run_image(img, $urandom_range(6) != 0);
            end
            round++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (check_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

### tga_rle_decoder_unit.f
rtl/trd_pkg.sv
rtl/trd_ctrl.sv
rtl/trd_datapath.sv
rtl/tga_rle_decoder_unit.sv
sim/rle_pixel_checker.sv
sim/tb_top.sv
